// File: hdl/periodic_task_table_scheduler_assert.svh
// Assertion macros for the periodic task table scheduler.
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PTTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTTS_ASSERT_NOW(label, ante, cons, msg)
`define PTTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/ptts_pkg.sv
// Package: sizes, codes and shared types of the periodic task table scheduler.
`default_nettype none
package ptts_pkg;
  localparam int PRIORITY_LEVELS = 4;
  localparam int SLOTS_PER_LEVEL = 4;
  localparam int NUM_ENTRIES = PRIORITY_LEVELS * SLOTS_PER_LEVEL;

  localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int SLOT_W = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int LEVEL_W  = 2;
  localparam int TICKS_W  = 16;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_DONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE,
    ST_DEL
  } state_e;

  typedef struct packed {
    action_e             op;
    logic                reject;
    logic [ID_W-1:0]     task_id;
    logic [LEVEL_W-1:0]  level;
    logic [TICKS_W-1:0]  period;
    logic [TICKS_W-1:0]  delay;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qslot_t;

  typedef struct packed {
    kind_e            kind;
    logic             ok;
    logic [ID_W-1:0]  task_id;
    logic [POS_W-1:0] level;
    logic [POS_W-1:0] slot;
    logic             last;
  } rsp_t;
endpackage
`default_nettype wire

// File: hdl/ptts_req_if.sv
// Request channel: one action item per handshake.
`default_nettype none
interface ptts_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptts_pkg::ACTION_W-1:0] action;
  logic [ptts_pkg::ID_W-1:0]     task_id;
  logic [ptts_pkg::LEVEL_W-1:0]  level;
  logic [ptts_pkg::TICKS_W-1:0]  period_ticks;
  logic [ptts_pkg::TICKS_W-1:0]  initial_delay;

  modport source (output valid, action, task_id, level, period_ticks, initial_delay,
                  input ready);
  modport sink (input valid, action, task_id, level, period_ticks, initial_delay,
                output ready);
endinterface
`default_nettype wire

// File: hdl/ptts_rsp_if.sv
// Result channel: replies, dispatches and tick done markers.
`default_nettype none
interface ptts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ptts_pkg::KIND_W-1:0] kind;
  logic                        ok;
  logic [ptts_pkg::ID_W-1:0]   out_task_id;
  logic [ptts_pkg::POS_W-1:0]  out_level;
  logic [ptts_pkg::POS_W-1:0]  out_slot;
  logic                        last;

  modport source (output valid, kind, ok, out_task_id, out_level, out_slot, last,
                  input ready);
  modport sink (input valid, kind, ok, out_task_id, out_level, out_slot, last,
                output ready);
endinterface
`default_nettype wire

// File: hdl/ptts_front.sv
// Front end: accepts request items, drops unused codes, prechecks arguments.
`default_nettype none
module ptts_front (
  ptts_req_if.sink         req,
  input  logic             full,
  output ptts_pkg::qslot_t push
);
  ptts_pkg::action_e op;

  assign op = ptts_pkg::action_e'(req.action);
  assign req.ready = !full;

  always_comb begin
    push.valid        = req.valid && !full && (op != ptts_pkg::ACT_NONE);
    push.cmd.op       = op;
    push.cmd.task_id  = req.task_id;
    push.cmd.level    = req.level;
    push.cmd.period   = req.period_ticks;
    push.cmd.delay    = req.initial_delay;
    unique case (op)
      ptts_pkg::ACT_CREATE: begin
        push.cmd.reject = (req.task_id == '0) ||
                          (int'(req.level) >= ptts_pkg::PRIORITY_LEVELS);
      end
      ptts_pkg::ACT_DELETE: push.cmd.reject = (req.task_id == '0);
      default:              push.cmd.reject = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/ptts_queue.sv
// Command queue between the front end and the table engine.
`default_nettype none
module ptts_queue (
  input  logic             clk,
  input  logic             rst,
  input  ptts_pkg::qslot_t push,
  output logic             full,
  output ptts_pkg::qslot_t head,
  input  logic             pop
);
  ptts_pkg::cmd_t                mem [ptts_pkg::QUEUE_DEPTH];
  logic [ptts_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ptts_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ptts_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == ptts_pkg::QCNT_W'(ptts_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ptts_pkg::QPTR_W'(ptts_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ptts_pkg::QPTR_W'(ptts_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/ptts_back.sv
// Table engine: task table, scan sequencer and result register.
`default_nettype none
module ptts_back (
  input  logic             clk,
  input  logic             rst,
  input  ptts_pkg::qslot_t head,
  output logic             pop,
  ptts_rsp_if.source       rsp
);
  logic                           entry_valid     [ptts_pkg::NUM_ENTRIES];
  logic [ptts_pkg::ID_W-1:0]      entry_id        [ptts_pkg::NUM_ENTRIES];
  logic [ptts_pkg::TICKS_W-1:0]   entry_period    [ptts_pkg::NUM_ENTRIES];
  logic [ptts_pkg::TICKS_W-1:0]   entry_countdown [ptts_pkg::NUM_ENTRIES];

  ptts_pkg::state_e               state;
  ptts_pkg::state_e               state_next;
  ptts_pkg::cmd_t                 cmd;
  logic [ptts_pkg::LVL_W-1:0]     scan_level;
  logic [ptts_pkg::SLOT_W-1:0]    scan_slot;
  logic [ptts_pkg::IDX_W-1:0]     ent;
  logic                           scan_end;
  logic                           out_free;
  logic                           rsp_valid;
  ptts_pkg::rsp_t                 res;
  ptts_pkg::rsp_t                 res_next;
  logic                           emit;
  logic                           advance;
  logic                           tick_wr;
  logic                           del_wr;
  logic                           create_wr;
  logic                           free_found;
  logic [ptts_pkg::SLOT_W-1:0]    free_slot;
  logic [ptts_pkg::IDX_W-1:0]     free_idx;
  logic [ptts_pkg::IDX_W-1:0]     try_idx;
  logic                           cur_valid;
  logic [ptts_pkg::TICKS_W-1:0]   cur_cd;
  logic                           cur_match;

  assign ent = ptts_pkg::IDX_W'(int'(scan_level) * ptts_pkg::SLOTS_PER_LEVEL + int'(scan_slot));
  assign scan_end = (scan_level == ptts_pkg::LVL_W'(ptts_pkg::PRIORITY_LEVELS - 1)) &&
                    (scan_slot == ptts_pkg::SLOT_W'(ptts_pkg::SLOTS_PER_LEVEL - 1));
  assign out_free  = !rsp_valid || rsp.ready;
  assign cur_valid = entry_valid[ent];
  assign cur_cd    = entry_countdown[ent];
  assign cur_match = cur_valid && (entry_id[ent] == cmd.task_id);

  // first empty slot of the requested level
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    free_idx   = '0;
    try_idx    = '0;
    for (int s = 0; s < ptts_pkg::SLOTS_PER_LEVEL; s++) begin
      try_idx = ptts_pkg::IDX_W'(int'(head.cmd.level) * ptts_pkg::SLOTS_PER_LEVEL + s);
      if (!free_found && !head.cmd.reject && !entry_valid[try_idx]) begin
        free_found = 1'b1;
        free_slot  = ptts_pkg::SLOT_W'(s);
        free_idx   = try_idx;
      end
    end
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    advance   = 1'b0;
    tick_wr   = 1'b0;
    del_wr    = 1'b0;
    create_wr = 1'b0;
    res_next  = '0;
    unique case (state)
      ptts_pkg::ST_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          res_next.task_id = head.cmd.task_id;
          res_next.last    = 1'b1;
          unique case (head.cmd.op)
            ptts_pkg::ACT_CREATE: begin
              emit          = 1'b1;
              create_wr     = !head.cmd.reject && free_found;
              res_next.kind = ptts_pkg::KIND_CREATE;
              res_next.ok   = create_wr;
              if (create_wr) begin
                res_next.level = ptts_pkg::POS_W'(head.cmd.level);
                res_next.slot  = ptts_pkg::POS_W'(free_slot);
              end
            end
            ptts_pkg::ACT_DELETE: begin
              emit          = head.cmd.reject;
              res_next.kind = ptts_pkg::KIND_DELETE;
            end
            default: ;
          endcase
        end
      end
      ptts_pkg::ST_TICK: begin
        res_next.kind    = ptts_pkg::KIND_DISPATCH;
        res_next.ok      = 1'b1;
        res_next.task_id = entry_id[ent];
        res_next.level   = ptts_pkg::POS_W'(scan_level);
        res_next.slot    = ptts_pkg::POS_W'(scan_slot);
        if (cur_valid && cur_cd == '0) begin
          emit    = out_free;
          advance = out_free;
          tick_wr = out_free;
        end else begin
          advance = 1'b1;
          tick_wr = cur_valid;
        end
      end
      ptts_pkg::ST_DONE: begin
        res_next.kind = ptts_pkg::KIND_DONE;
        res_next.ok   = 1'b1;
        res_next.last = 1'b1;
        emit          = out_free;
      end
      ptts_pkg::ST_DEL: begin
        res_next.kind    = ptts_pkg::KIND_DELETE;
        res_next.task_id = cmd.task_id;
        res_next.last    = 1'b1;
        if (cur_match) begin
          res_next.ok    = 1'b1;
          res_next.level = ptts_pkg::POS_W'(scan_level);
          res_next.slot  = ptts_pkg::POS_W'(scan_slot);
          emit           = out_free;
          del_wr         = out_free;
        end else if (scan_end) begin
          emit = out_free;
        end else begin
          advance = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptts_pkg::ST_IDLE: begin
        if (pop && head.cmd.op == ptts_pkg::ACT_TICK) begin
          state_next = ptts_pkg::ST_TICK;
        end else if (pop && head.cmd.op == ptts_pkg::ACT_DELETE && !head.cmd.reject) begin
          state_next = ptts_pkg::ST_DEL;
        end
      end
      ptts_pkg::ST_TICK: begin
        if (advance && scan_end) begin
          state_next = ptts_pkg::ST_DONE;
        end
      end
      ptts_pkg::ST_DONE: begin
        if (emit) begin
          state_next = ptts_pkg::ST_IDLE;
        end
      end
      ptts_pkg::ST_DEL: begin
        if (emit) begin
          state_next = ptts_pkg::ST_IDLE;
        end
      end
      default: state_next = ptts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptts_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
    if (pop) begin
      cmd        <= head.cmd;
      scan_level <= '0;
      scan_slot  <= '0;
    end else if (advance) begin
      if (scan_slot == ptts_pkg::SLOT_W'(ptts_pkg::SLOTS_PER_LEVEL - 1)) begin
        scan_slot  <= '0;
        scan_level <= scan_level + 1'b1;
      end else begin
        scan_slot <= scan_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < ptts_pkg::NUM_ENTRIES; e++) begin
        entry_valid[e] <= 1'b0;
      end
    end else if (create_wr) begin
      entry_valid[free_idx] <= 1'b1;
    end else if (del_wr) begin
      entry_valid[ent] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (create_wr) begin
      entry_id[free_idx]        <= head.cmd.task_id;
      entry_period[free_idx]    <= head.cmd.period;
      entry_countdown[free_idx] <= head.cmd.delay;
    end else if (tick_wr) begin
      entry_countdown[ent] <= (cur_cd == '0) ? entry_period[ent] - 1'b1 : cur_cd - 1'b1;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.kind        = res.kind;
  assign rsp.ok          = res.ok;
  assign rsp.out_task_id = res.task_id;
  assign rsp.out_level   = res.level;
  assign rsp.out_slot    = res.slot;
  assign rsp.last        = res.last;
endmodule
`default_nettype wire

// File: hdl/periodic_task_table_scheduler.sv
// Top level of the periodic task table scheduler.
// Usage:
//   req carries one action item per valid/ready handshake: tick, create or
//   delete (code 3 is taken and dropped). rsp carries result items; the
//   final result of each action has last set.
//   Items first enter a two-entry command queue, so req keeps taking items
//   while the table engine works or while a result waits in its register.
//   Create reply and rejected delete: the item passes the command queue and
//   then the result register. A delete scans the table one entry per cycle,
//   up to all 16 entries. A tick is popped, scans all 16 entries one per
//   cycle while rsp is not stalled, and then issues the done marker.
//   The table engine's single scan pointer serves one action at a time.
//   When rsp stalls, the engine holds at the next entry that has a result
//   to issue; the queue fills and then req.ready falls.
//   Reset (rst, synchronous) empties the table and the queue and drops any
//   pending result; no clearing pass is needed afterwards.
`default_nettype none
module periodic_task_table_scheduler (
  input  logic       clk,
  input  logic       rst,
  ptts_req_if.sink   req,
  ptts_rsp_if.source rsp
);
`include "periodic_task_table_scheduler_assert.svh"

  ptts_pkg::qslot_t push;
  ptts_pkg::qslot_t head;
  logic             full;
  logic             pop;

  ptts_front u_front (
    .req  (req),
    .full (full),
    .push (push)
  );

  ptts_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  ptts_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

  `PTTS_ASSERT_NOW(a_no_push_full, push.valid, !full, "push into full queue")
  `PTTS_ASSERT_NOW(a_no_pop_empty, pop, head.valid, "pop from empty queue")
  `PTTS_ASSERT_NOW(a_drop_unused, req.valid && req.ready && req.action == ptts_pkg::ACT_NONE, !push.valid, "unused action queued")
  `PTTS_ASSERT_NOW(a_dispatch_not_last, rsp.valid && rsp.kind == ptts_pkg::KIND_DISPATCH, !rsp.last && rsp.ok, "dispatch marked last")
endmodule
`default_nettype wire

// File: dv/periodic_task_table_scheduler_checker.sv
// Checker: watches both channels, predicts the task table and compares each result item.
module periodic_task_table_scheduler_checker
  import ptts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ptts_req_if  req,
  ptts_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   items_in,
  output int   results_out,
  output int   dispatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic               tbl_valid  [NUM_ENTRIES];
  logic [ID_W-1:0]    tbl_id     [NUM_ENTRIES];
  logic [TICKS_W-1:0] tbl_period [NUM_ENTRIES];
  logic [TICKS_W-1:0] tbl_count  [NUM_ENTRIES];
  rsp_t               sched_expq [$];
  rsp_t               seen;

  function automatic rsp_t make_result(kind_e k, logic ok, logic [ID_W-1:0] id, int lvl,
                                       int slot, logic last);
    rsp_t r;
    r.kind    = k;
    r.ok      = ok;
    r.task_id = id;
    r.level   = lvl[POS_W-1:0];
    r.slot    = slot[POS_W-1:0];
    r.last    = last;
    return r;
  endfunction

  function automatic void predict_action(action_e act, logic [ID_W-1:0] id,
                                         logic [LEVEL_W-1:0] lvl, logic [TICKS_W-1:0] per,
                                         logic [TICKS_W-1:0] dly);
    int   e;
    int   s;
    logic hit;
    hit = 1'b0;
    case (act)
      ACT_TICK: begin
        for (e = 0; e < NUM_ENTRIES; e++) begin
          if (tbl_valid[e]) begin
            if (tbl_count[e] == '0) begin
              sched_expq.push_back(make_result(KIND_DISPATCH, 1'b1, tbl_id[e],
                                               e / SLOTS_PER_LEVEL, e % SLOTS_PER_LEVEL, 1'b0));
              tbl_count[e] = tbl_period[e] - 1'b1;
            end else begin
              tbl_count[e] = tbl_count[e] - 1'b1;
            end
          end
        end
        sched_expq.push_back(make_result(KIND_DONE, 1'b1, '0, 0, 0, 1'b1));
      end
      ACT_CREATE: begin
        if (id != '0 && int'(lvl) < PRIORITY_LEVELS) begin
          for (s = 0; s < SLOTS_PER_LEVEL && !hit; s++) begin
            e = int'(lvl) * SLOTS_PER_LEVEL + s;
            if (!tbl_valid[e]) begin
              tbl_valid[e]  = 1'b1;
              tbl_id[e]     = id;
              tbl_period[e] = per;
              tbl_count[e]  = dly;
              hit = 1'b1;
              sched_expq.push_back(make_result(KIND_CREATE, 1'b1, id, int'(lvl), s, 1'b1));
            end
          end
        end
        if (!hit) sched_expq.push_back(make_result(KIND_CREATE, 1'b0, id, 0, 0, 1'b1));
      end
      ACT_DELETE: begin
        if (id != '0) begin
          for (e = 0; e < NUM_ENTRIES && !hit; e++) begin
            if (tbl_valid[e] && tbl_id[e] == id) begin
              tbl_valid[e]  = 1'b0;
              tbl_id[e]     = '0;
              tbl_period[e] = '0;
              tbl_count[e]  = '0;
              hit = 1'b1;
              sched_expq.push_back(make_result(KIND_DELETE, 1'b1, id, e / SLOTS_PER_LEVEL,
                                               e % SLOTS_PER_LEVEL, 1'b1));
            end
          end
        end
        if (!hit) sched_expq.push_back(make_result(KIND_DELETE, 1'b0, id, 0, 0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic cmp_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (sched_expq.size() == 0) begin
      report_mismatch($sformatf("unexpected item kind %0d id %0d", got.kind, got.task_id));
      return;
    end
    want = sched_expq.pop_front();
    cmp_field("kind", got.kind, want.kind);
    cmp_field("ok", got.ok, want.ok);
    cmp_field("task id", got.task_id, want.task_id);
    cmp_field("level", got.level, want.level);
    cmp_field("slot", got.slot, want.slot);
    cmp_field("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        tbl_valid[e]  = 1'b0;
        tbl_id[e]     = '0;
        tbl_period[e] = '0;
        tbl_count[e]  = '0;
      end
      sched_expq.delete();
      items_in    = 0;
      results_out = 0;
      dispatches  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.kind    = kind_e'(rsp.kind);
        seen.ok      = rsp.ok;
        seen.task_id = rsp.out_task_id;
        seen.level   = rsp.out_level;
        seen.slot    = rsp.out_slot;
        seen.last    = rsp.last;
        check_result(seen);
        results_out++;
        if (seen.kind == KIND_DISPATCH) dispatches++;
      end
      if (req.valid && req.ready) begin
        predict_action(action_e'(req.action), req.task_id, req.level, req.period_ticks,
                       req.initial_delay);
        items_in++;
      end
    end
    pending = sched_expq.size();
  end
endmodule

// File: dv/periodic_task_table_scheduler_tb.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module periodic_task_table_scheduler_tb;
  import ptts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst;
  logic idle_on = 1'b1;
  int   cycles = 0;
  int   fails;
  int   pending;
  int   items_in;
  int   results_out;
  int   dispatches;

  ptts_req_if req_ch ();
  ptts_rsp_if rsp_ch ();

  periodic_task_table_scheduler u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  periodic_task_table_scheduler_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fails),
    .pending     (pending),
    .items_in    (items_in),
    .results_out (results_out),
    .dispatches  (dispatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic send_item(action_e act, logic [ID_W-1:0] id, logic [LEVEL_W-1:0] lvl,
                           logic [TICKS_W-1:0] per, logic [TICKS_W-1:0] dly);
    while (idle_on && $urandom_range(0, 99) < 19) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.task_id       <= id;
    req_ch.level         <= lvl;
    req_ch.period_ticks  <= per;
    req_ch.initial_delay <= dly;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 20) return ID_W'($urandom_range(0, 255));
    return ID_W'($urandom_range(1, 10));
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks(int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return TICKS_W'($urandom_range(0, 65535));
    if (r < 13) return '0;
    if (r < 15) return '1;
    return TICKS_W'($urandom_range(0, top));
  endfunction

  initial begin
    int n;
    int r;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_TICK;
    req_ch.task_id       <= '0;
    req_ch.level         <= '0;
    req_ch.period_ticks  <= '0;
    req_ch.initial_delay <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(ACT_TICK,   8'd0,   2'd0, 16'd0,     16'd0);
    send_item(ACT_CREATE, 8'd0,   2'd1, 16'd5,     16'd5);
    send_item(ACT_CREATE, 8'd255, 2'd0, 16'd0,     16'd0);
    send_item(ACT_CREATE, 8'd1,   2'd0, 16'hFFFF,  16'hFFFF);
    send_item(ACT_CREATE, 8'd2,   2'd0, 16'd1,     16'd1);
    send_item(ACT_CREATE, 8'd3,   2'd0, 16'd2,     16'd0);
    send_item(ACT_CREATE, 8'd4,   2'd0, 16'd3,     16'd3);
    send_item(ACT_CREATE, 8'd5,   2'd3, 16'd3,     16'd2);
    send_item(ACT_CREATE, 8'd5,   2'd3, 16'hAAAA,  16'h5555);
    send_item(ACT_CREATE, 8'hA5,  2'd2, 16'h5555,  16'hAAAA);
    send_item(ACT_NONE,   8'hFF,  2'd3, 16'hFFFF,  16'hFFFF);
    send_item(ACT_TICK,   8'd0,   2'd0, 16'd0,     16'd0);
    send_item(ACT_TICK,   8'hFF,  2'd3, 16'hFFFF,  16'hFFFF);
    send_item(ACT_TICK,   8'd0,   2'd0, 16'd0,     16'd0);
    send_item(ACT_DELETE, 8'd0,   2'd0, 16'd0,     16'd0);
    send_item(ACT_DELETE, 8'd5,   2'd0, 16'd0,     16'd0);
    send_item(ACT_DELETE, 8'd5,   2'd0, 16'd0,     16'd0);
    send_item(ACT_DELETE, 8'd5,   2'd0, 16'd0,     16'd0);
    send_item(ACT_DELETE, 8'd255, 2'd3, 16'hFFFF,  16'hFFFF);
    send_item(ACT_CREATE, 8'd7,   2'd0, 16'd0,     16'd1);
    send_item(ACT_TICK,   8'd0,   2'd0, 16'd0,     16'd0);
    send_item(ACT_TICK,   8'd0,   2'd0, 16'd0,     16'd0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      idle_on = !(n >= 120 && n < 220);
      r = $urandom_range(0, 99);
      if (r < 38) begin
        send_item(ACT_TICK, pick_id(), LEVEL_W'($urandom_range(0, 3)), pick_ticks(6),
                  pick_ticks(5));
        n++;
      end else if (r < 70) begin
        send_item(ACT_CREATE, pick_id(), LEVEL_W'($urandom_range(0, 3)), pick_ticks(6),
                  pick_ticks(5));
        n++;
      end else if (r < 96) begin
        send_item(ACT_DELETE, pick_id(), LEVEL_W'($urandom_range(0, 3)), pick_ticks(6),
                  pick_ticks(5));
        n++;
      end else begin
        send_item(ACT_NONE, pick_id(), LEVEL_W'($urandom_range(0, 3)), pick_ticks(6),
                  pick_ticks(5));
      end
    end
    req_ch.valid <= 1'b0;
    idle_on = 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d request items taken, %0d result items checked, %0d of them dispatches.",
             items_in, results_out, dispatches);
    $display("Covered ticks, creates, deletes, the unused action code and back-pressure.");
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
